// File: design/block_signal_station_controller_defines.svh
// ----------------------------------------------------------------------------
// block signal station controller: assertion macros
// shared checking helpers, clocked on i_clk and disabled while in reset
// ----------------------------------------------------------------------------
`ifndef BLOCK_SIGNAL_STATION_CONTROLLER_DEFINES_SVH
`define BLOCK_SIGNAL_STATION_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define BSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// types, codes and constants shared by the block signal station controller
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

    // elapsed-second counter width
    localparam int TIMER_BITS = 8;
    localparam int CFG_BITS   = 8;
    localparam int CMP_W      = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
    localparam int MAX_RES    = 8;
    localparam int RES_IDX_W  = $clog2(MAX_RES);
    localparam int Q_DEPTH    = 2;

    typedef logic [TIMER_BITS-1:0] t_timer;
    typedef logic [CMP_W-1:0]      t_cmp;
    typedef logic [CFG_BITS-1:0]   t_cfg;

    // item kinds
    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_CENTRAL = 2'd1,
        FUNC_NEXT    = 2'd2,
        FUNC_LAST    = 2'd3
    } t_func;

    // actions
    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_LIGHT   = 3'd1,
        ACT_RESET   = 3'd2,
        ACT_CENTRAL = 3'd3,
        ACT_NEXT    = 3'd4,
        ACT_LAST    = 3'd5,
        ACT_ALARM   = 3'd6
    } t_action;

    // message codes
    localparam logic [3:0] MSG_CROSSED = 4'd1;
    localparam logic [3:0] MSG_RED     = 4'd2;
    localparam logic [3:0] MSG_GREEN   = 4'd3;
    localparam logic [3:0] MSG_HAVE    = 4'd4;
    localparam logic [3:0] MSG_NONE    = 4'd5;
    localparam logic [3:0] MSG_STOP    = 4'd6;
    localparam logic [3:0] MSG_START   = 4'd7;
    localparam logic [3:0] MSG_READY   = 4'd8;
    localparam logic [3:0] MSG_ALIVE   = 4'd9;
    localparam logic [3:0] MSG_LIVING  = 4'd10;

    // alarm codes
    localparam logic [3:0] AL_INVALID    = 4'd0;
    localparam logic [3:0] AL_UNEXPECTED = 4'd1;
    localparam logic [3:0] AL_RUNNING    = 4'd2;
    localparam logic [3:0] AL_CROSSING   = 4'd3;
    localparam logic [3:0] AL_PARTIAL    = 4'd4;
    localparam logic [3:0] AL_NOLEAVE    = 4'd5;
    localparam logic [3:0] AL_STARTUP    = 4'd6;

    // light levels
    localparam logic [3:0] LIGHT_GREEN = 4'd0;
    localparam logic [3:0] LIGHT_RED   = 4'd1;
    localparam logic [3:0] CODE_ZERO   = 4'd0;

    // register indexes
    localparam logic [1:0] REG_WHEEL_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_STARTUP_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_GREEN_TIMEOUT   = 2'd2;
    localparam logic [1:0] REG_PARTIAL_TIMEOUT = 2'd3;

    // register reset values
    localparam t_cfg WHEEL_THRESHOLD_RST = 8'd8;
    localparam t_cfg STARTUP_TIMEOUT_RST = 8'd15;
    localparam t_cfg GREEN_TIMEOUT_RST   = 8'd30;
    localparam t_cfg PARTIAL_TIMEOUT_RST = 8'd30;

    // one action of a run
    typedef struct packed {
        t_action    action;
        logic [3:0] code;
    } t_act;

    // a whole run of actions for one item
    typedef struct packed {
        t_act [MAX_RES-1:0]   acts;
        logic [RES_IDX_W-1:0] last_idx;
    } t_run;

    // front to queue
    typedef struct packed {
        logic valid;
        t_run run;
    } t_push;

    // queue head towards the back end
    typedef struct packed {
        logic valid;
        t_run run;
    } t_head;

    // queue status
    typedef struct packed {
        logic                       full;
        logic [$clog2(Q_DEPTH+1)-1:0] count;
    } t_qstat;

    function automatic t_act mk_act(input t_action act, input logic [3:0] code);
        t_act a;
        a.action = act;
        a.code   = code;
        return a;
    endfunction

    // saturating one-second step
    function automatic t_timer timer_inc(input t_timer t);
        return (t == '1) ? t : t + t_timer'(1);
    endfunction

endpackage

`default_nettype wire

// File: design/bsc_if.sv
// ----------------------------------------------------------------------------
// bsc interfaces
// valid/ready channels for items, results and register writes
// ----------------------------------------------------------------------------
`default_nettype none

// input items
interface bsc_in_if import bsc_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [3:0] msg_type;
    logic [7:0] wheel_counts;
    logic       prox_present;

    modport source (output valid, output func, output msg_type, output wheel_counts,
                    output prox_present, input ready);
    modport sink   (input valid, input func, input msg_type, input wheel_counts,
                    input prox_present, output ready);
endinterface

// result items
interface bsc_out_if import bsc_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [3:0] code;
    logic       last;

    modport source (output valid, output action, output code, output last, input ready);
    modport sink   (input valid, input action, input code, input last, output ready);
endinterface

// register writes
interface bsc_cfg_if import bsc_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] index;
    t_cfg       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/bsc_front.sv
// ----------------------------------------------------------------------------
// bsc_front
// accepts items, updates controller state and builds the run of actions
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_front import bsc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bsc_in_if.sink    i_in,
    bsc_cfg_if.sink   i_cfg,
    input  wire logic i_q_full,
    output t_push     o_push
);

    // configuration registers
    t_cfg r_wheel_threshold, r_startup_timeout, r_green_timeout, r_partial_timeout;

    // controller state
    logic   r_halted, r_in_startup, r_got_next, r_got_last, r_got_central;
    logic   r_green_allowed, r_green_requested, r_light_green;
    logic   r_occ_ahead, r_occ_behind, r_counting;
    t_timer r_startup_sec, r_green_sec, r_count_sec;

    logic   n_halted, n_in_startup, n_got_next, n_got_last, n_got_central;
    logic   n_green_allowed, n_green_requested, n_light_green;
    logic   n_occ_ahead, n_occ_behind, n_counting;
    t_timer n_startup_sec, n_green_sec, n_count_sec;

    t_act [MAX_RES-1:0] list;
    logic [RES_IDX_W:0] cnt;
    logic [3:0]         msg;
    logic               accept;

    assign i_in.ready  = !i_q_full;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_in.valid && !i_q_full;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_threshold <= WHEEL_THRESHOLD_RST;
            r_startup_timeout <= STARTUP_TIMEOUT_RST;
            r_green_timeout   <= GREEN_TIMEOUT_RST;
            r_partial_timeout <= PARTIAL_TIMEOUT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_WHEEL_THRESHOLD: r_wheel_threshold <= i_cfg.data;
                REG_STARTUP_TIMEOUT: r_startup_timeout <= i_cfg.data;
                REG_GREEN_TIMEOUT:   r_green_timeout   <= i_cfg.data;
                REG_PARTIAL_TIMEOUT: r_partial_timeout <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // decision logic: next state and action run
    always_comb begin
        n_halted          = r_halted;
        n_in_startup      = r_in_startup;
        n_got_next        = r_got_next;
        n_got_last        = r_got_last;
        n_got_central     = r_got_central;
        n_green_allowed   = r_green_allowed;
        n_green_requested = r_green_requested;
        n_light_green     = r_light_green;
        n_occ_ahead       = r_occ_ahead;
        n_occ_behind      = r_occ_behind;
        n_counting        = r_counting;
        n_startup_sec     = r_startup_sec;
        n_green_sec       = r_green_sec;
        n_count_sec       = r_count_sec;
        list              = '0;
        cnt               = '0;
        msg               = i_in.prox_present ? MSG_HAVE : MSG_NONE;

        case (i_in.func)
            FUNC_TICK: begin
                n_startup_sec = timer_inc(r_startup_sec);
                n_green_sec   = timer_inc(r_green_sec);
                n_count_sec   = timer_inc(r_count_sec);
                if (r_in_startup) begin
                    // handshake ran out of time
                    if (t_cmp'(n_startup_sec) > t_cmp'(r_startup_timeout)) begin
                        list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_ALARM, AL_STARTUP);
                        cnt = cnt + 1'b1;
                        n_in_startup      = 1'b0;
                        n_halted          = 1'b1;
                        n_got_next        = 1'b0;
                        n_got_last        = 1'b0;
                        n_got_central     = 1'b0;
                        n_green_requested = 1'b0;
                        n_green_allowed   = 1'b0;
                    end
                end else if (!r_halted) begin
                    if (i_in.wheel_counts != '0) begin
                        if (i_in.wheel_counts >= r_wheel_threshold) begin
                            // complete crossing
                            if (!r_occ_behind) begin
                                list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_ALARM, AL_CROSSING);
                                cnt = cnt + 1'b1;
                            end
                            if (r_occ_ahead) begin
                                list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_ALARM, AL_CROSSING);
                                cnt = cnt + 1'b1;
                            end
                            n_occ_ahead     = 1'b1;
                            n_occ_behind    = 1'b0;
                            n_green_allowed = 1'b0;
                            n_light_green   = 1'b0;
                            n_counting      = 1'b0;
                            list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_LIGHT, LIGHT_RED);
                            cnt = cnt + 1'b1;
                            list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_RESET, CODE_ZERO);
                            cnt = cnt + 1'b1;
                            list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_NEXT, MSG_CROSSED);
                            cnt = cnt + 1'b1;
                            list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_LAST, MSG_CROSSED);
                            cnt = cnt + 1'b1;
                            list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_CENTRAL, MSG_CROSSED);
                            cnt = cnt + 1'b1;
                        end else if (r_counting &&
                                     t_cmp'(n_count_sec) > t_cmp'(r_partial_timeout)) begin
                            // partial count timed out
                            list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_ALARM, AL_PARTIAL);
                            cnt = cnt + 1'b1;
                            n_counting = 1'b0;
                            list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_RESET, CODE_ZERO);
                            cnt = cnt + 1'b1;
                        end else if (!r_counting) begin
                            n_count_sec = '0;
                            n_counting  = 1'b1;
                        end
                    end
                    // green held too long
                    if (n_light_green && t_cmp'(n_green_sec) > t_cmp'(r_green_timeout)) begin
                        list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_ALARM, AL_NOLEAVE);
                        cnt = cnt + 1'b1;
                        list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_LIGHT, LIGHT_RED);
                        cnt = cnt + 1'b1;
                        n_light_green = 1'b0;
                    end
                end
            end

            FUNC_CENTRAL: begin
                case (i_in.msg_type)
                    MSG_RED: begin
                        n_green_requested = 1'b0;
                        n_light_green     = 1'b0;
                        list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_LIGHT, LIGHT_RED);
                        cnt = cnt + 1'b1;
                    end
                    MSG_GREEN: begin
                        n_green_requested = 1'b1;
                        if (r_green_allowed) begin
                            list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_LIGHT, LIGHT_GREEN);
                            n_green_sec   = '0;
                            n_light_green = 1'b1;
                        end else begin
                            list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_LIGHT, LIGHT_RED);
                            n_light_green = 1'b0;
                        end
                        cnt = cnt + 1'b1;
                    end
                    MSG_STOP: begin
                        n_halted          = 1'b1;
                        n_in_startup      = 1'b0;
                        n_green_requested = 1'b0;
                        n_green_allowed   = 1'b0;
                        n_occ_ahead       = 1'b0;
                        n_occ_behind      = 1'b0;
                        n_counting        = 1'b0;
                        n_got_next        = 1'b0;
                        n_got_last        = 1'b0;
                        n_got_central     = 1'b0;
                        n_light_green     = 1'b0;
                        list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_RESET, CODE_ZERO);
                        cnt = cnt + 1'b1;
                        list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_LIGHT, LIGHT_RED);
                        cnt = cnt + 1'b1;
                    end
                    MSG_ALIVE: begin
                        list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_CENTRAL, MSG_LIVING);
                        cnt = cnt + 1'b1;
                    end
                    MSG_START: begin
                        if (!r_halted) begin
                            list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_ALARM, AL_RUNNING);
                            cnt = cnt + 1'b1;
                        end
                        n_got_central = 1'b1;
                        n_occ_behind  = i_in.prox_present;
                        list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_CENTRAL, msg);
                        cnt = cnt + 1'b1;
                        list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_NEXT, msg);
                        cnt = cnt + 1'b1;
                        list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_LAST, msg);
                        cnt = cnt + 1'b1;
                        // handshake step
                        if (!r_in_startup) begin
                            n_in_startup  = 1'b1;
                            n_startup_sec = '0;
                        end else if (n_got_next && n_got_last && n_got_central) begin
                            n_got_next    = 1'b0;
                            n_got_last    = 1'b0;
                            n_got_central = 1'b0;
                            n_in_startup  = 1'b0;
                            n_halted      = 1'b0;
                            list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_RESET, CODE_ZERO);
                            cnt = cnt + 1'b1;
                            list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_CENTRAL, MSG_READY);
                            cnt = cnt + 1'b1;
                        end
                    end
                    default: begin
                        list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_ALARM, AL_INVALID);
                        cnt = cnt + 1'b1;
                    end
                endcase
            end

            FUNC_NEXT: begin
                if (i_in.msg_type == MSG_CROSSED) begin
                    if (!r_occ_ahead) begin
                        list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_ALARM, AL_UNEXPECTED);
                        cnt = cnt + 1'b1;
                    end
                    n_occ_ahead = 1'b0;
                    if (r_occ_behind) n_green_allowed = 1'b1;
                end else if (i_in.msg_type == MSG_HAVE || i_in.msg_type == MSG_NONE) begin
                    if (!r_halted) begin
                        list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_ALARM, AL_RUNNING);
                        cnt = cnt + 1'b1;
                    end else begin
                        n_got_next      = 1'b1;
                        n_occ_ahead     = (i_in.msg_type == MSG_HAVE);
                        n_occ_behind    = i_in.prox_present;
                        n_green_allowed = !n_occ_ahead && i_in.prox_present;
                        if (!r_in_startup) begin
                            n_in_startup  = 1'b1;
                            n_startup_sec = '0;
                        end else if (n_got_next && n_got_last && n_got_central) begin
                            n_got_next    = 1'b0;
                            n_got_last    = 1'b0;
                            n_got_central = 1'b0;
                            n_in_startup  = 1'b0;
                            n_halted      = 1'b0;
                            list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_RESET, CODE_ZERO);
                            cnt = cnt + 1'b1;
                            list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_CENTRAL, MSG_READY);
                            cnt = cnt + 1'b1;
                        end
                    end
                end else begin
                    list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_ALARM, AL_INVALID);
                    cnt = cnt + 1'b1;
                end
            end

            FUNC_LAST: begin
                if (i_in.msg_type == MSG_CROSSED) begin
                    if (r_occ_behind) begin
                        list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_ALARM, AL_UNEXPECTED);
                        cnt = cnt + 1'b1;
                    end
                    n_occ_behind = 1'b1;
                    if (!r_occ_ahead) n_green_allowed = 1'b1;
                end else if (i_in.msg_type == MSG_HAVE || i_in.msg_type == MSG_NONE) begin
                    if (!r_halted) begin
                        list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_ALARM, AL_RUNNING);
                        cnt = cnt + 1'b1;
                    end else begin
                        n_got_last = 1'b1;
                        if (!r_in_startup) begin
                            n_in_startup  = 1'b1;
                            n_startup_sec = '0;
                        end else if (n_got_next && n_got_last && n_got_central) begin
                            n_got_next    = 1'b0;
                            n_got_last    = 1'b0;
                            n_got_central = 1'b0;
                            n_in_startup  = 1'b0;
                            n_halted      = 1'b0;
                            list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_RESET, CODE_ZERO);
                            cnt = cnt + 1'b1;
                            list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_CENTRAL, MSG_READY);
                            cnt = cnt + 1'b1;
                        end
                    end
                end else begin
                    list[cnt[RES_IDX_W-1:0]] = mk_act(ACT_ALARM, AL_INVALID);
                    cnt = cnt + 1'b1;
                end
            end

            default: ;
        endcase

        // an empty run carries a single none action
        if (cnt == '0) begin
            list[0] = mk_act(ACT_NONE, CODE_ZERO);
            cnt     = cnt + 1'b1;
        end
    end

    // push the run into the queue
    always_comb begin
        o_push.valid        = accept;
        o_push.run.acts     = list;
        o_push.run.last_idx = RES_IDX_W'(cnt - 1'b1);
    end

    // state update on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_halted          <= 1'b1;
            r_in_startup      <= 1'b0;
            r_got_next        <= 1'b0;
            r_got_last        <= 1'b0;
            r_got_central     <= 1'b0;
            r_green_allowed   <= 1'b0;
            r_green_requested <= 1'b0;
            r_light_green     <= 1'b0;
            r_occ_ahead       <= 1'b0;
            r_occ_behind      <= 1'b0;
            r_counting        <= 1'b0;
            r_startup_sec     <= '0;
            r_green_sec       <= '0;
            r_count_sec       <= '0;
        end else if (accept) begin
            r_halted          <= n_halted;
            r_in_startup      <= n_in_startup;
            r_got_next        <= n_got_next;
            r_got_last        <= n_got_last;
            r_got_central     <= n_got_central;
            r_green_allowed   <= n_green_allowed;
            r_green_requested <= n_green_requested;
            r_light_green     <= n_light_green;
            r_occ_ahead       <= n_occ_ahead;
            r_occ_behind      <= n_occ_behind;
            r_counting        <= n_counting;
            r_startup_sec     <= n_startup_sec;
            r_green_sec       <= n_green_sec;
            r_count_sec       <= n_count_sec;
        end
    end

endmodule

`default_nettype wire

// File: design/bsc_queue.sv
// ----------------------------------------------------------------------------
// bsc_queue
// short fifo of action runs between the front and back ends
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_queue import bsc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_push     i_push,
    input  wire logic i_pop,
    output t_head     o_head,
    output t_qstat    o_stat
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH+1);

    t_run             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_stat.full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_stat.count = r_count;
    assign o_head.valid = (r_count != '0);
    assign o_head.run   = r_mem[r_rptr];
    assign do_push      = i_push.valid && !o_stat.full;
    assign do_pop       = i_pop && o_head.valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wptr] <= i_push.run;
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push)
                r_wptr <= (r_wptr == PTR_W'(Q_DEPTH-1)) ? '0 : r_wptr + 1'b1;
            if (do_pop)
                r_rptr <= (r_rptr == PTR_W'(Q_DEPTH-1)) ? '0 : r_rptr + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/bsc_back.sv
// ----------------------------------------------------------------------------
// bsc_back
// walks the head run one action per cycle into the output register while taken
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_back import bsc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_head     i_head,
    output logic      o_pop,
    bsc_out_if.source o_out
);

    logic                 r_valid, r_last;
    t_act                 r_act;
    logic [RES_IDX_W-1:0] r_idx;
    logic                 load, at_end;

    assign load   = !r_valid || o_out.ready;
    assign at_end = (r_idx == i_head.run.last_idx);
    assign o_pop  = load && i_head.valid && at_end;

    assign o_out.valid  = r_valid;
    assign o_out.action = r_act.action;
    assign o_out.code   = r_act.code;
    assign o_out.last   = r_last;

    // output register, reloaded when empty or taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= i_head.valid;
            if (i_head.valid) r_idx <= at_end ? '0 : r_idx + 1'b1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (load && i_head.valid) begin
            r_act  <= i_head.run.acts[r_idx];
            r_last <= at_end;
        end
    end

endmodule

`default_nettype wire

// File: design/block_signal_station_controller.sv
// ----------------------------------------------------------------------------
// block_signal_station_controller
// railway block signal controller for one station
// ----------------------------------------------------------------------------
// Each accepted item (tick or message) yields a run of one to seven actions
// on the output channel, one action per clock while the output is taken, the
// final one flagged by last; this rate is set by the output serialiser. The
// front end decides the whole run in the cycle an item is accepted and can
// take a new item every cycle while the two-entry run queue has room; when
// the queue is empty, the run of a taken item is written into the queue and
// then loaded into the output register, which presents its first action.
// Register writes are taken at once.
`default_nettype none
`include "block_signal_station_controller_defines.svh"

module block_signal_station_controller import bsc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bsc_in_if.sink    i_in,
    bsc_cfg_if.sink   i_cfg,
    bsc_out_if.source o_out
);

    t_push  push;
    t_head  head;
    t_qstat q_stat;
    logic   pop;

    // decision front end
    bsc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_full (q_stat.full),
        .o_push   (push)
    );

    // run queue
    bsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    // action serialiser
    bsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

    // checks
    `BSC_ASSERT_NOW(a_full_blocks_input, q_stat.full, !i_in.ready, "input ready while queue full")
    `BSC_ASSERT_NOW(a_none_alone, o_out.valid && o_out.action == ACT_NONE, o_out.last, "stray none")
    `BSC_ASSERT_NEXT(a_queue_drains, q_stat.count != '0 && !o_out.valid, o_out.valid, "run stuck")
    `BSC_ASSERT_NEXT(a_accept_fills, i_in.valid && i_in.ready, q_stat.count != '0, "not queued")

endmodule

`default_nettype wire
